/* rtl/obt_pkg.sv */
// obt_pkg: shared constants for the oriented box overlap test unit
// no dependencies; used by the input channel interface, the top level and its checker
package obt_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int PIPE_DEPTH          = 5;

endpackage

/* rtl/obt_in_if.sv */
// obt_in_if: input channel carrying one pair of oriented boxes per item
// depends on obt_pkg for the default coordinate width
interface obt_in_if #(
    parameter int W = obt_pkg::COORD_WIDTH_DEFAULT
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_origin_x;
    logic signed [W-1:0] first_origin_y;
    logic signed [W-1:0] first_width_end_x;
    logic signed [W-1:0] first_width_end_y;
    logic signed [W-1:0] first_height_end_x;
    logic signed [W-1:0] first_height_end_y;
    logic signed [W-1:0] second_origin_x;
    logic signed [W-1:0] second_origin_y;
    logic signed [W-1:0] second_width_end_x;
    logic signed [W-1:0] second_width_end_y;
    logic signed [W-1:0] second_height_end_x;
    logic signed [W-1:0] second_height_end_y;

    modport source (
        output valid,
        output first_origin_x, first_origin_y,
        output first_width_end_x, first_width_end_y,
        output first_height_end_x, first_height_end_y,
        output second_origin_x, second_origin_y,
        output second_width_end_x, second_width_end_y,
        output second_height_end_x, second_height_end_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_origin_x, first_origin_y,
        input  first_width_end_x, first_width_end_y,
        input  first_height_end_x, first_height_end_y,
        input  second_origin_x, second_origin_y,
        input  second_width_end_x, second_width_end_y,
        input  second_height_end_x, second_height_end_y,
        output ready
    );
endinterface

/* rtl/obt_out_if.sv */
// obt_out_if: result channel carrying the overlap verdict per item
// no dependencies
interface obt_out_if;
    logic valid;
    logic ready;
    logic colliding;

    modport source (
        output valid,
        output colliding,
        input  ready
    );

    modport sink (
        input  valid,
        input  colliding,
        output ready
    );
endinterface

/* rtl/oriented_box_overlap_test_unit.sv */
// oriented_box_overlap_test_unit: separating axis test on two oriented rectangles
// depends on obt_pkg, obt_in_if and obt_out_if
//
// channel   dir  handshake      payload
// boxes     in   valid/ready    twelve signed corner coordinates
// result    out  valid/ready    colliding
//
// one item per cycle sustained while result.ready stays high
// stages: input reg, edge axes, dot products, interval min/max, verdict reg
// each stage holds its item until the next one frees; boxes.ready stays high
// while any stage is empty, so items keep entering behind a stalled result
// rst_n clears all stage valid flags; data registers are not reset
module oriented_box_overlap_test_unit #(
    parameter int COORD_WIDTH = obt_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    obt_in_if.sink    boxes,
    obt_out_if.source result
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int DW = PW + 2;

    // stage valid flags and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, in_rdy;

    // box, point (origin, width end, height end), component
    logic signed [W-1:0]  s1_pt_reg [2][3][2];
    logic signed [W-1:0]  s1_pt_next [2][3][2];
    logic signed [W-1:0]  s2_pt_reg [2][3][2];
    logic signed [AW-1:0] s2_axis_reg [4][2];
    logic signed [AW-1:0] s2_axis_next [4][2];
    logic                 s2_degen_reg;
    logic                 s2_degen_next;
    // axis, box, point
    logic signed [PW-1:0] s3_dot_reg [4][2][3];
    logic signed [PW-1:0] s3_dot_next [4][2][3];
    logic                 s3_degen_reg;
    logic signed [DW-1:0] s4_min_reg [4][2];
    logic signed [DW-1:0] s4_max_reg [4][2];
    logic signed [DW-1:0] s4_min_next [4][2];
    logic signed [DW-1:0] s4_max_next [4][2];
    logic                 s4_degen_reg;
    logic                 colliding_reg;
    logic                 colliding_next;

    assign rdy4   = !out_valid_reg || result.ready;
    assign rdy3   = !v4_reg || rdy4;
    assign rdy2   = !v3_reg || rdy3;
    assign rdy1   = !v2_reg || rdy2;
    assign in_rdy = !v1_reg || rdy1;

    assign boxes.ready      = in_rdy;
    assign result.valid     = out_valid_reg;
    assign result.colliding = colliding_reg;

    always_comb
    begin
        s1_pt_next[0][0][0] = W'(boxes.first_origin_x);
        s1_pt_next[0][0][1] = W'(boxes.first_origin_y);
        s1_pt_next[0][1][0] = W'(boxes.first_width_end_x);
        s1_pt_next[0][1][1] = W'(boxes.first_width_end_y);
        s1_pt_next[0][2][0] = W'(boxes.first_height_end_x);
        s1_pt_next[0][2][1] = W'(boxes.first_height_end_y);
        s1_pt_next[1][0][0] = W'(boxes.second_origin_x);
        s1_pt_next[1][0][1] = W'(boxes.second_origin_y);
        s1_pt_next[1][1][0] = W'(boxes.second_width_end_x);
        s1_pt_next[1][1][1] = W'(boxes.second_width_end_y);
        s1_pt_next[1][2][0] = W'(boxes.second_height_end_x);
        s1_pt_next[1][2][1] = W'(boxes.second_height_end_y);
    end

    // edge directions of both boxes
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            for (int e = 0; e < 2; e++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    s2_axis_next[2*b+e][c] = AW'(s1_pt_reg[b][e+1][c])
                                           - AW'(s1_pt_reg[b][0][c]);
                end
            end
        end
        s2_degen_next = (s2_axis_next[0][0] == '0 && s2_axis_next[0][1] == '0) ||
                        (s2_axis_next[1][0] == '0 && s2_axis_next[1][1] == '0);
    end

    // projections of the three given corners onto every axis
    always_comb
    begin
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int p = 0; p < 3; p++)
                begin
                    s3_dot_next[a][b][p] =
                        PW'(s2_pt_reg[b][p][0]) * PW'(s2_axis_reg[a][0]) +
                        PW'(s2_pt_reg[b][p][1]) * PW'(s2_axis_reg[a][1]);
                end
            end
        end
    end

    // fourth corner projection and interval ends
    always_comb
    begin
        logic signed [DW-1:0] d0, d1, d2, d3;
        logic signed [DW-1:0] lo_a, lo_b, hi_a, hi_b;
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                d0   = DW'(s3_dot_reg[a][b][0]);
                d1   = DW'(s3_dot_reg[a][b][1]);
                d3   = DW'(s3_dot_reg[a][b][2]);
                d2   = d1 + d3 - d0;
                lo_a = (d0 < d1) ? d0 : d1;
                hi_a = (d0 < d1) ? d1 : d0;
                lo_b = (d2 < d3) ? d2 : d3;
                hi_b = (d2 < d3) ? d3 : d2;
                s4_min_next[a][b] = (lo_a < lo_b) ? lo_a : lo_b;
                s4_max_next[a][b] = (hi_a < hi_b) ? hi_b : hi_a;
            end
        end
    end

    always_comb
    begin
        logic sep;
        sep = 1'b0;
        for (int a = 0; a < 4; a++)
        begin
            sep = sep || (s4_max_reg[a][0] < s4_min_reg[a][1]) ||
                         (s4_max_reg[a][1] < s4_min_reg[a][0]);
        end
        colliding_next = !s4_degen_reg && !sep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_rdy)
            begin
                v1_reg <= boxes.valid;
            end
            if (rdy1)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy2)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy3)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (boxes.valid && in_rdy)
        begin
            s1_pt_reg <= s1_pt_next;
        end
        if (v1_reg && rdy1)
        begin
            s2_pt_reg    <= s1_pt_reg;
            s2_axis_reg  <= s2_axis_next;
            s2_degen_reg <= s2_degen_next;
        end
        if (v2_reg && rdy2)
        begin
            s3_dot_reg   <= s3_dot_next;
            s3_degen_reg <= s2_degen_reg;
        end
        if (v3_reg && rdy3)
        begin
            s4_min_reg   <= s4_min_next;
            s4_max_reg   <= s4_max_next;
            s4_degen_reg <= s3_degen_reg;
        end
        if (v4_reg && rdy4)
        begin
            colliding_reg <= colliding_next;
        end
    end

endmodule

/* rtl/obt_checker.sv */
// obt_checker: port-level checks on item flow through the overlap test unit
// depends on obt_pkg; bound to oriented_box_overlap_test_unit below
module obt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_colliding
);

    localparam int DEPTH = obt_pkg::PIPE_DEPTH;
    localparam int CW    = $clog2(DEPTH + 1) + 1;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // items accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            cnt_next = cnt_next + CW'(1);
        end
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result shown with no item in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("more items in flight than pipeline stages");

    a_ready_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CW'(DEPTH) |-> in_ready)
        else $error("input refused while a stage is free");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_colliding))
        else $error("stalled result changed");

endmodule

bind oriented_box_overlap_test_unit obt_checker u_obt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (boxes.valid),
    .in_ready      (boxes.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_colliding (result.colliding)
);
